>>> src/tad_pkg.sv
package tad_pkg;

    // cordic coordinate and angle width: 16-bit sample, 8 fraction bits, growth and sign
    localparam int CW = 27;

    localparam int TABLE_LEN = 24;

    // angle accumulator is in units of 2^-16 degree
    localparam logic signed [CW-1:0] ANGLE_180 = 27'sd11796480;

    localparam logic signed [CW-1:0] TILT_MAX = 27'sd23040;
    localparam logic signed [CW-1:0] TILT_MIN = -27'sd23040;
    localparam logic signed [CW-1:0] ROUND_HALF = 27'sd256;

    localparam int ROUND_SHIFT = 9;

    // floor(n / 25) as (n * DIV25_MUL) >> DIV25_SHIFT, exact for n up to 25600
    localparam int DIV25_SHIFT = 24;
    localparam int DIV25_MUL_W = 20;
    localparam logic [DIV25_MUL_W-1:0] DIV25_MUL = DIV25_MUL_W'((2**DIV25_SHIFT + 24) / 25);

    localparam logic [6:0] PCT_FULL = 7'd100;

    localparam logic [7:0] PWM_PERIOD_RST = 8'd55;
    localparam logic [6:0] DRIVE_OFFSET_RST = 7'd55;

    localparam logic ADDR_PWM_PERIOD = 1'b0;
    localparam logic ADDR_DRIVE_OFFSET = 1'b1;

    // atan(2^-i) in degrees, units of 2^-16 degree
    localparam logic signed [CW-1:0] ATAN_Q16 [TABLE_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] acc;
    } t_cord;

endpackage

>>> src/tad_cordic_cell.sv
module tad_cordic_cell
    import tad_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cord i_data,
    output logic  o_ready,
    input  logic  i_next_ready,
    output logic  o_valid,
    output t_cord o_data
);

    logic  r_valid;
    t_cord r_data;
    t_cord n_data;

    assign o_ready = !r_valid || i_next_ready;

    always_comb begin
        n_data = i_data;
        if (i_data.x >= 0) begin
            n_data.z   = i_data.z + (i_data.x >>> STAGE);
            n_data.x   = i_data.x - (i_data.z >>> STAGE);
            n_data.acc = i_data.acc + ATAN_Q16[STAGE];
        end else begin
            n_data.z   = i_data.z - (i_data.x >>> STAGE);
            n_data.x   = i_data.x + (i_data.z >>> STAGE);
            n_data.acc = i_data.acc - ATAN_Q16[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> src/tad_drive.sv
module tad_drive
    import tad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_pwm_period,
    input  logic [6:0]  i_drive_offset,
    input  logic        i_valid,
    input  t_cord       i_data,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_motor_reverse,
    output logic [10:0] o_duty_count,
    output logic signed [15:0] o_tilt_angle
);

    // stage a: rounded and clamped angle
    logic               r_a_valid;
    logic signed [15:0] r_a_tilt;
    // stage b: direction and scaled percentage
    logic               r_b_valid;
    logic signed [15:0] r_b_tilt;
    logic               r_b_dir;
    logic [15:0]        r_b_num;
    // stage c: output register
    logic               r_c_valid;
    logic signed [15:0] r_c_tilt;
    logic               r_c_dir;
    logic [10:0]        r_c_count;

    logic ready_a, ready_b, ready_c;

    logic signed [CW-1:0] rounded;
    logic signed [15:0]   n_a_tilt;
    logic signed [15:0]   abs_tilt;
    logic [8:0]           pct_sum;
    logic [6:0]           mag;
    logic                 n_b_dir;
    logic [6:0]           pct_frac;
    logic [15:0]          n_b_num;
    logic [15:0]          period_p1;
    logic [DIV25_MUL_W+15:0] quot_prod;

    assign ready_c = !r_c_valid || !i_stall;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    always_comb begin
        rounded = (i_data.acc + ROUND_HALF) >>> ROUND_SHIFT;
        if (i_data.zero) begin
            n_a_tilt = 16'sd0;
        end else if (rounded > TILT_MAX) begin
            n_a_tilt = TILT_MAX[15:0];
        end else if (rounded < TILT_MIN) begin
            n_a_tilt = TILT_MIN[15:0];
        end else begin
            n_a_tilt = rounded[15:0];
        end
    end

    always_comb begin
        abs_tilt  = (r_a_tilt < 0) ? -r_a_tilt : r_a_tilt;
        pct_sum   = {1'b0, abs_tilt[14:7]} + {2'b00, i_drive_offset};
        if (r_a_tilt == 16'sd0) begin
            mag = 7'd0;
        end else if (pct_sum > {2'b00, PCT_FULL}) begin
            mag = PCT_FULL;
        end else begin
            mag = pct_sum[6:0];
        end
        // small negative angle with no offset truncates to zero drive, forward
        n_b_dir   = (r_a_tilt < 0) && (mag != 7'd0);
        pct_frac  = n_b_dir ? (PCT_FULL - mag) : mag;
        period_p1 = {8'd0, i_pwm_period} + 16'd1;
        n_b_num   = {9'd0, pct_frac} * period_p1;
    end

    assign quot_prod = {{DIV25_MUL_W{1'b0}}, r_b_num} * {16'd0, DIV25_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_a_tilt <= n_a_tilt;
        end
        if (ready_b && r_a_valid) begin
            r_b_tilt <= r_a_tilt;
            r_b_dir  <= n_b_dir;
            r_b_num  <= n_b_num;
        end
        if (ready_c && r_b_valid) begin
            r_c_tilt  <= r_b_tilt;
            r_c_dir   <= r_b_dir;
            r_c_count <= quot_prod[DIV25_SHIFT+10:DIV25_SHIFT];
        end
    end

    assign o_valid         = r_c_valid;
    assign o_motor_reverse = r_c_dir;
    assign o_duty_count    = r_c_count;
    assign o_tilt_angle    = r_c_tilt;

endmodule

>>> src/tilt_angle_to_pwm_drive.sv
// channel  | handshake          | payload
// input    | i_valid / o_stall  | i_accel_x[15:0], i_accel_z[15:0] (signed)
// output   | o_valid / i_stall  | o_motor_reverse, o_duty_count[10:0], o_tilt_angle[15:0]
// config   | apb psel/penable   | paddr 0: pwm_period[7:0], paddr 4: drive_offset[6:0]
//
// one item per cycle unless i_stall holds the output; one cordic cell per
// iteration followed by round/clamp, percentage/scale and divide-by-25 stages
// each stage loads when it is empty or its successor moves, so bubbles collapse
// and o_stall rises only when every stage holds an item and the output is stalled
// synchronous active-low reset clears valid bits and sets both registers to 55
module tilt_angle_to_pwm_drive
    import tad_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_motor_reverse,
    output logic [10:0] o_duty_count,
    output logic signed [15:0] o_tilt_angle
);

    localparam int STAGES = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    logic [7:0] r_pwm_period;
    logic [6:0] r_drive_offset;

    logic  link_valid [STAGES+1];
    logic  link_ready [STAGES+1];
    t_cord link_data  [STAGES+1];

    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] z_in;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= PWM_PERIOD_RST;
            r_drive_offset <= DRIVE_OFFSET_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ADDR_PWM_PERIOD:   r_pwm_period   <= pwdata[7:0];
                ADDR_DRIVE_OFFSET: r_drive_offset <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ADDR_PWM_PERIOD:   prdata = {24'd0, r_pwm_period};
            ADDR_DRIVE_OFFSET: prdata = {25'd0, r_drive_offset};
            default:           prdata = 32'd0;
        endcase
    end

    // samples scaled by 256; negative z is turned by 180 degrees first
    assign x_in = {{(CW-24){i_accel_x[15]}}, i_accel_x, 8'd0};
    assign z_in = {{(CW-24){i_accel_z[15]}}, i_accel_z, 8'd0};

    always_comb begin
        link_data[0].zero = (i_accel_x == 16'sd0) && (i_accel_z == 16'sd0);
        if (i_accel_z < 0) begin
            link_data[0].x   = -x_in;
            link_data[0].z   = -z_in;
            link_data[0].acc = (i_accel_x >= 0) ? ANGLE_180 : -ANGLE_180;
        end else begin
            link_data[0].x   = x_in;
            link_data[0].z   = z_in;
            link_data[0].acc = '0;
        end
    end

    assign link_valid[0] = i_valid;
    assign o_stall       = !link_ready[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_cell
        tad_cordic_cell #(
            .STAGE(k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (link_valid[k]),
            .i_data       (link_data[k]),
            .o_ready      (link_ready[k]),
            .i_next_ready (link_ready[k+1]),
            .o_valid      (link_valid[k+1]),
            .o_data       (link_data[k+1])
        );
    end

    tad_drive u_drive (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pwm_period    (r_pwm_period),
        .i_drive_offset  (r_drive_offset),
        .i_valid         (link_valid[STAGES]),
        .i_data          (link_data[STAGES]),
        .o_ready         (link_ready[STAGES]),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_motor_reverse (o_motor_reverse),
        .o_duty_count    (o_duty_count),
        .o_tilt_angle    (o_tilt_angle)
    );

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side can move");

    a_zero_angle_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tilt_angle == 16'sd0) |-> (o_duty_count == 11'd0 && !o_motor_reverse))
        else $error("zero angle produced drive");

    a_reverse_needs_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_motor_reverse) |-> (o_tilt_angle < 0))
        else $error("reverse set for non-negative angle");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty_count <= 11'd1024 && o_tilt_angle <= 16'sd23040
                     && o_tilt_angle >= -16'sd23040))
        else $error("result out of range");

endmodule
